@@ design/ile_pkg.sv @@
package ile_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int POS_W        = 8;
  localparam int WORD_W       = 32;
  localparam int LEN_W        = 5;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DEL_HEAD = 3'd4,
    OP_DEL_AT   = 3'd5,
    OP_DEL_TAIL = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] at;
    logic             rd_hit;
    logic             rd_miss;
    status_t          status;
  } cmd_t;

endpackage

@@ design/ile_cell.sv @@
module ile_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  ile_pkg::cmd_t               cmd,
  input  logic [ile_pkg::WORD_W-1:0]  left_word,
  input  logic [ile_pkg::WORD_W-1:0]  right_word,
  input  logic [ile_pkg::WORD_W-1:0]  new_word,
  output logic [ile_pkg::WORD_W-1:0]  word
);

  localparam logic [ile_pkg::POS_W-1:0] MY_IDX = IDX[ile_pkg::POS_W-1:0];

  logic [ile_pkg::WORD_W-1:0] word_r;
  logic [ile_pkg::WORD_W-1:0] word_nxt;

  // Open a gap: cells above the slot take the left neighbor, the slot takes
  // the new word. Close a gap: the slot and all above take the right neighbor.
  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (MY_IDX > cmd.at) begin
        word_nxt = left_word;
      end else if (MY_IDX == cmd.at) begin
        word_nxt = new_word;
      end
    end else if (cmd.del) begin
      if (MY_IDX >= cmd.at) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

@@ design/ile_ctrl.sv @@
module ile_ctrl #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic [2:0]                 opcode,
  input  logic [ile_pkg::POS_W-1:0]  position,
  input  logic [CW-1:0]              count,
  output ile_pkg::cmd_t              cmd
);

  localparam int CMP_W = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] tail_x;
  logic             empty;
  logic             full;

  assign pos_x  = CMP_W'(position);
  assign cnt_x  = CMP_W'(count);
  assign tail_x = cnt_x - CMP_W'(1);
  assign empty  = (count == '0);
  assign full   = (cnt_x >= CMP_W'(CAPACITY));

  always_comb begin
    cmd         = '0;
    cmd.status  = ile_pkg::ST_OK;
    unique case (opcode)
      ile_pkg::OP_READ: begin
        if (empty) begin
          cmd.rd_miss = 1'b1;
          cmd.status  = ile_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          cmd.rd_miss = 1'b1;
          cmd.status  = ile_pkg::ST_RANGE;
        end else begin
          cmd.rd_hit  = 1'b1;
        end
      end
      ile_pkg::OP_INS_HEAD: begin
        if (full) cmd.status = ile_pkg::ST_FULL;
        else cmd.ins = 1'b1;
      end
      ile_pkg::OP_INS_TAIL: begin
        if (full) begin
          cmd.status = ile_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cmd.at  = cnt_x[ile_pkg::POS_W-1:0];
        end
      end
      ile_pkg::OP_INS_AT: begin
        if (pos_x > cnt_x) begin
          cmd.status = ile_pkg::ST_RANGE;
        end else if (full) begin
          cmd.status = ile_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cmd.at  = position;
        end
      end
      ile_pkg::OP_DEL_HEAD: begin
        if (empty) cmd.status = ile_pkg::ST_EMPTY;
        else cmd.del = 1'b1;
      end
      ile_pkg::OP_DEL_AT: begin
        if (empty) begin
          cmd.status = ile_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          cmd.status = ile_pkg::ST_RANGE;
        end else begin
          cmd.del = 1'b1;
          cmd.at  = position;
        end
      end
      ile_pkg::OP_DEL_TAIL: begin
        if (empty) begin
          cmd.status = ile_pkg::ST_EMPTY;
        end else begin
          cmd.del = 1'b1;
          cmd.at  = tail_x[ile_pkg::POS_W-1:0];
        end
      end
      default: begin
        cmd.status = ile_pkg::ST_RANGE;
      end
    endcase
  end

endmodule

@@ design/indexed_list_engine_unit.sv @@
// Bounded ordered list of signed 32-bit words, held in a chain of cells.
// Input channel (in_valid / in_stall): one transaction carries an opcode,
// a position and a value. Opcodes: read, insert head/tail/at, delete
// head/at/tail. Output channel (out_valid / out_stall): one transaction per
// input transaction with the word read (-1 on a miss, 0 for non-reads), a
// status (ok, empty, out of range, full) and the list length afterwards.
// The result is registered and appears in the cycle after the input is
// accepted. One transaction per cycle unless stalled. Every cell compares
// its own slot with the target position and shifts from its neighbor in
// the same cycle, so the decode plus one cell update sets the cycle.
// Reset (rst_n low, synchronous): the length goes to zero and the output
// channel empties. Word storage is not cleared; slots at or above the
// length are never read.
// When the receiver stalls, the result register holds and in_stall rises,
// so no input is taken until the result is accepted.
// A refused operation leaves the list and its length unchanged.
module indexed_list_engine_unit #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_opcode,
  input  logic [ile_pkg::POS_W-1:0]   in_position,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_read_value,
  output logic [1:0]                  out_status,
  output logic [ile_pkg::LEN_W-1:0]   out_length
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int WORD_W = ile_pkg::WORD_W;
  localparam int LEN_W  = ile_pkg::LEN_W;

  logic                 in_fire;
  ile_pkg::cmd_t        cmd;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;
  logic [WORD_W-1:0]    words [CAPACITY];
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    rd_nxt;

  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_read_value_r;
  ile_pkg::status_t     out_status_r;
  logic [LEN_W-1:0]     out_length_r;

  // Take a new transaction whenever the result register is free or drains.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Decode the operation against the current length.
  ile_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .opcode   (in_opcode),
    .position (in_position),
    .count    (cnt_r),
    .cmd      (cmd)
  );

  // Chain of storage cells; slot 0 is the head.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_body
      assign left_w = words[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = words[g+1];
    end

    ile_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .en         (in_fire),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .new_word   (in_value),
      .word       (words[g])
    );
  end

  // Pick the addressed word: each slot gates its word onto a shared OR.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_position == i[ile_pkg::POS_W-1:0]) begin
        rd_word = rd_word | words[i];
      end
    end
  end

  always_comb begin
    if (cmd.rd_miss) begin
      rd_nxt = '1;
    end else if (cmd.rd_hit) begin
      rd_nxt = rd_word;
    end else begin
      rd_nxt = '0;
    end
  end

  // Advance the length on an accepted insert or delete.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.del) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register: load on accept, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_value_r <= rd_nxt;
      out_status_r     <= cmd.status;
      out_length_r     <= LEN_W'(cnt_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_length     = out_length_r;

  // Length never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAPACITY)
    else $error("list length above capacity");

  // An accepted transaction always produces a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction left no result");

  // A refused operation leaves the length unchanged.
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd.status != ile_pkg::ST_OK) |=> $stable(cnt_r))
    else $error("refused operation changed the length");

  // Insert and delete are exclusive, and a miss only comes with a bad status.
  a_cmd_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.del) && (!cmd.rd_miss || (cmd.status != ile_pkg::ST_OK)))
    else $error("inconsistent decoded command");

  // An accepted insert grows the list by exactly one.
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd.ins |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the list by one");

endmodule

@@ dv/tb_indexed_list_engine_unit.sv @@
`timescale 1ns / 1ps

module tb_indexed_list_engine_unit;

  // Opcode seven has no operation behind it; the block must refuse it.
  localparam logic [2:0] OP_RESERVED = 3'd7;
  // Word returned by a read that misses.
  localparam logic signed [ile_pkg::WORD_W-1:0] READ_MISS = -32'sd1;
  localparam logic signed [ile_pkg::WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [ile_pkg::WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam int LIST_CAP      = ile_pkg::CAPACITY_DEF;
  localparam int IDX_W         = $clog2(LIST_CAP);
  // Length of the receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES   = 100;
  localparam int RANDOM_CHUNKS = 21;
  localparam int CHUNK_ITEMS   = 50;

  // One expected result transaction.
  typedef struct {
    logic signed [ile_pkg::WORD_W-1:0] read_value;
    ile_pkg::status_t                  status;
    logic [ile_pkg::LEN_W-1:0]         length;
  } list_result_t;

  logic                              clk         = 1'b0;
  logic                              rst_n       = 1'b0;
  logic                              in_valid    = 1'b0;
  logic                              in_stall;
  logic [2:0]                        in_opcode   = '0;
  logic [ile_pkg::POS_W-1:0]         in_position = '0;
  logic signed [ile_pkg::WORD_W-1:0] in_value    = '0;
  logic                              out_valid;
  logic                              out_stall   = 1'b0;
  logic signed [ile_pkg::WORD_W-1:0] out_read_value;
  logic [1:0]                        out_status;
  logic [ile_pkg::LEN_W-1:0]         out_length;

  // Shadow copy of the list, advanced once per offered transaction.
  logic signed [ile_pkg::WORD_W-1:0] list_words [LIST_CAP];
  int unsigned                       list_len = 0;

  list_result_t pending_results [$];
  int           mismatches = 0;
  int           results_seen = 0;

  // Idling switches for each side; tests turn them off for quiet stretches.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  // Hold-off requests from the tests, served by the receiver process.
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left  = 0;

  indexed_list_engine_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_status    (out_status),
    .out_length    (out_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Open a slot at position at and drop the word into it; later entries move up.
  function automatic void open_slot(int unsigned at, logic signed [ile_pkg::WORD_W-1:0] word);
    for (int unsigned i = list_len; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    list_len++;
  endfunction

  // Remove the entry at position at; later entries move down.
  function automatic void close_slot(int unsigned at);
    for (int unsigned i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
  endfunction

  // Apply one operation to the shadow list and return the result it must yield.
  // A refused operation leaves the shadow list untouched.
  function automatic list_result_t apply_list_op(logic [2:0] op,
                                                 logic [ile_pkg::POS_W-1:0] pos,
                                                 logic signed [ile_pkg::WORD_W-1:0] word);
    list_result_t r;
    bit           full;
    full         = (list_len >= LIST_CAP);
    r.read_value = '0;
    r.status     = ile_pkg::ST_OK;
    case (op)
      ile_pkg::OP_READ: begin
        if (list_len == 0) begin
          r.read_value = READ_MISS;
          r.status     = ile_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          r.read_value = READ_MISS;
          r.status     = ile_pkg::ST_RANGE;
        end else begin
          r.read_value = list_words[pos[IDX_W-1:0]];
        end
      end
      ile_pkg::OP_INS_HEAD: begin
        if (full) r.status = ile_pkg::ST_FULL;
        else open_slot(0, word);
      end
      ile_pkg::OP_INS_TAIL: begin
        if (full) r.status = ile_pkg::ST_FULL;
        else open_slot(list_len, word);
      end
      ile_pkg::OP_INS_AT: begin
        // The range check wins over the full check.
        if (pos > list_len) r.status = ile_pkg::ST_RANGE;
        else if (full) r.status = ile_pkg::ST_FULL;
        else open_slot(pos, word);
      end
      ile_pkg::OP_DEL_HEAD: begin
        if (list_len == 0) r.status = ile_pkg::ST_EMPTY;
        else close_slot(0);
      end
      ile_pkg::OP_DEL_AT: begin
        if (list_len == 0) r.status = ile_pkg::ST_EMPTY;
        else if (pos >= list_len) r.status = ile_pkg::ST_RANGE;
        else close_slot(pos);
      end
      ile_pkg::OP_DEL_TAIL: begin
        if (list_len == 0) r.status = ile_pkg::ST_EMPTY;
        else list_len--;
      end
      default: r.status = ile_pkg::ST_RANGE;
    endcase
    r.length = list_len[ile_pkg::LEN_W-1:0];
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Offer one transaction and return at the edge where it is taken.
  // Valid stays high on return so a back-to-back transaction needs no extra step.
  task automatic issue_list_op(input logic [2:0] op, input logic [ile_pkg::POS_W-1:0] pos,
                               input logic signed [ile_pkg::WORD_W-1:0] word);
    list_result_t want;
    while (tx_idle_en && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    want = apply_list_op(op, pos, word);
    pending_results.push_back(want);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Draw one random transaction. Positions mostly land near the live length so
  // that inserts and deletes in the middle hit; the rest cover the whole field.
  task automatic draw_list_op(input int ins_pct, output logic [2:0] op,
                              output logic [ile_pkg::POS_W-1:0] pos,
                              output logic signed [ile_pkg::WORD_W-1:0] word);
    int pick;
    pick = $urandom_range(99);
    if (pick < 2) begin
      op = OP_RESERVED;
    end else if (pick < 2 + ins_pct) begin
      case ($urandom_range(2))
        0:       op = ile_pkg::OP_INS_HEAD;
        1:       op = ile_pkg::OP_INS_TAIL;
        default: op = ile_pkg::OP_INS_AT;
      endcase
    end else if (pick < 22 + ins_pct) begin
      op = ile_pkg::OP_READ;
    end else begin
      case ($urandom_range(2))
        0:       op = ile_pkg::OP_DEL_HEAD;
        1:       op = ile_pkg::OP_DEL_AT;
        default: op = ile_pkg::OP_DEL_TAIL;
      endcase
    end
    if ($urandom_range(99) < 80) pos = ile_pkg::POS_W'($urandom_range(0, list_len + 1));
    else pos = ile_pkg::POS_W'($urandom_range(0, 255));
    case ($urandom_range(19))
      0:       word = WORD_MAX;
      1:       word = WORD_MIN;
      2:       word = READ_MISS;
      3:       word = '0;
      default: word = $urandom;
    endcase
  endtask

  // Empty-list refusals, the reserved opcode, extreme words, positions off the
  // end, and deletes from head, middle and tail until the list is empty again.
  task automatic test_short_list_edges();
    issue_list_op(ile_pkg::OP_READ,     8'd0,   '0);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd1,   32'sd5);
    issue_list_op(ile_pkg::OP_DEL_HEAD, 8'd0,   '0);
    issue_list_op(ile_pkg::OP_DEL_AT,   8'd0,   '0);
    issue_list_op(ile_pkg::OP_DEL_TAIL, 8'd0,   '0);
    issue_list_op(OP_RESERVED,          8'd0,   $urandom);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd0,   WORD_MAX);
    issue_list_op(ile_pkg::OP_INS_HEAD, 8'd0,   WORD_MIN);
    issue_list_op(ile_pkg::OP_INS_TAIL, 8'd0,   READ_MISS);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd1,   '0);
    issue_list_op(ile_pkg::OP_READ,     8'd0,   '0);
    issue_list_op(ile_pkg::OP_READ,     8'd3,   '0);
    issue_list_op(ile_pkg::OP_READ,     8'd4,   '0);
    issue_list_op(ile_pkg::OP_READ,     8'd255, '0);
    issue_list_op(ile_pkg::OP_DEL_AT,   8'd255, '0);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd255, 32'sd9);
    issue_list_op(OP_RESERVED,          8'd255, WORD_MAX);
    issue_list_op(ile_pkg::OP_DEL_AT,   8'd1,   '0);
    issue_list_op(ile_pkg::OP_DEL_HEAD, 8'd0,   '0);
    issue_list_op(ile_pkg::OP_DEL_TAIL, 8'd0,   '0);
    issue_list_op(ile_pkg::OP_DEL_AT,   8'd0,   '0);
  endtask

  // Fill to capacity, then try every insert flavor against the full list.
  // Inserting just past the length must report out of range, not full.
  task automatic test_full_list();
    for (int i = 0; i < LIST_CAP - 2; i++) issue_list_op(ile_pkg::OP_INS_TAIL, 8'd0, $urandom);
    issue_list_op(ile_pkg::OP_INS_HEAD, 8'd0, $urandom);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd8, $urandom);
    issue_list_op(ile_pkg::OP_INS_HEAD, 8'd0,  32'sd1);
    issue_list_op(ile_pkg::OP_INS_TAIL, 8'd0,  32'sd2);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd16, 32'sd3);
    issue_list_op(ile_pkg::OP_INS_AT,   8'd17, 32'sd4);
    issue_list_op(ile_pkg::OP_READ,     8'd15, '0);
    issue_list_op(ile_pkg::OP_READ,     8'd16, '0);
    issue_list_op(ile_pkg::OP_DEL_AT,   8'd15, '0);
    issue_list_op(ile_pkg::OP_DEL_AT,   8'd0,  '0);
    issue_list_op(ile_pkg::OP_DEL_TAIL, 8'd0,  '0);
  endtask

  // Random traffic in chunks that lean toward growing, balancing or shrinking,
  // so the length sweeps between empty and full many times. A run of chunks
  // in the middle has no idling on either side.
  task automatic test_random_mix();
    int                                ins_pct;
    bit                                quiet;
    logic [2:0]                        op;
    logic [ile_pkg::POS_W-1:0]         pos;
    logic signed [ile_pkg::WORD_W-1:0] word;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      quiet      = (chunk >= 8 && chunk < 12);
      tx_idle_en = !quiet;
      rx_idle_en = !quiet;
      case (chunk % 4)
        0:       ins_pct = 60;
        1:       ins_pct = 39;
        2:       ins_pct = 20;
        default: ins_pct = $urandom_range(20, 60);
      endcase
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        draw_list_op(ins_pct, op, pos, word);
        issue_list_op(op, pos, word);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the result side off for a long stretch while the sender keeps
  // offering back to back, so the block backs up and stalls its input.
  task automatic test_output_hold_off();
    logic [2:0]                        op;
    logic [ile_pkg::POS_W-1:0]         pos;
    logic signed [ile_pkg::WORD_W-1:0] word;
    tx_idle_en = 1'b0;
    hold_asked++;
    for (int k = 0; k < 40; k++) begin
      draw_list_op(39, op, pos, word);
      issue_list_op(op, pos, word);
    end
    tx_idle_en = 1'b1;
  endtask

  // Receiver: serve hold-off requests first, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left  <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(99) < 35);
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d status %0d length %0d",
                               out_read_value, out_status, out_length));
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value || out_status !== want.status ||
            out_length !== want.length)
          note_failure($sformatf({"result %0d: want value %0d status %0d length %0d,",
                                  " got value %0d status %0d length %0d"},
                                 results_seen, want.read_value, want.status,
                                 want.length, out_read_value, out_status, out_length));
      end
      results_seen++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_short_list_edges();
    test_full_list();
    test_random_mix();
    test_output_hold_off();
    // Drop valid, drain what is still in flight, then keep the clock running
    // so that any stray result shows.
    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("** indexed_list_engine_unit: PASSED **");
    end else begin
      $display("** indexed_list_engine_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("** indexed_list_engine_unit: FAILED **");
    $finish;
  end

endmodule
